[rtl/button_step_sequencer_defines.svh]
// assertion helpers shared by the checker
`ifndef BUTTON_STEP_SEQUENCER_DEFINES_SVH
`define BUTTON_STEP_SEQUENCER_DEFINES_SVH

// same-cycle implication, held off while in reset
`define BSS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("%m: check failed");

// next-cycle implication, held off while in reset
`define BSS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("%m: check failed");

`endif

[rtl/bss_pkg.sv]
package bss_pkg;

   localparam int COLUMNS = 8;
   localparam int ColWidth = $clog2(COLUMNS);
   localparam int PackColumns = (COLUMNS < 8) ? COLUMNS : 8;

   typedef logic [ColWidth-1:0] col_type;
   typedef logic [2:0] pitch_type;

   localparam col_type ColLast = col_type'(COLUMNS - 1);

   localparam logic [15:0] StepTicksReset = 16'd250;
   localparam logic [15:0] IdleTicksReset = 16'd3000;

   // register indexes on the csr port
   localparam logic CsrStepTicks = 1'b0;
   localparam logic CsrIdleTicks = 1'b1;

   // debouncer codes
   localparam logic [1:0] BtnInactive = 2'd0;
   localparam logic [1:0] BtnHeld     = 2'd1;

   // default pitches packed three bits each, column 0 lowest
   localparam logic [23:0] DefaultPattern = {3'd0, 3'd6, 3'd7, 3'd1,
                                             3'd2, 3'd1, 3'd7, 3'd3};

   typedef enum logic [1:0] {
      NOTE_NONE = 2'd0,
      NOTE_STOP = 2'd1,
      NOTE_PLAY = 2'd2
   } note_cmd_type;

   typedef struct packed {
      logic       enter_mode;
      logic       tick;
      logic [1:0] left_button;
      logic [1:0] right_button;
   } req_type;

   typedef struct packed {
      note_cmd_type note_cmd;
      logic [2:0]   note_index;
      logic         store_write;
      logic [2:0]   store_column;
      logic [2:0]   store_value;
      logic         redraw;
      logic [2:0]   cursor_column;
      logic         playing;
      logic [23:0]  pattern_word;
   } rsp_type;

   typedef struct packed {
      logic [15:0] step_ticks;
      logic [15:0] idle_ticks;
   } cfg_type;

   function automatic pitch_type default_pitch(input int c);
      pitch_type p;
      p = 3'd0;
      if (c < 8) begin
         p = DefaultPattern[3*c +: 3];
      end
      return p;
   endfunction

endpackage

[rtl/bss_in_reg.sv]
module bss_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bss_pkg::req_type req_payload,
   input  logic             advance,
   output logic             item_valid,
   output bss_pkg::req_type item
);

   logic             valid_ff, valid_in;
   bss_pkg::req_type item_ff;

   assign req_ready  = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

endmodule

[rtl/bss_core.sv]
module bss_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  bss_pkg::req_type item,
   input  bss_pkg::cfg_type cfg,
   output bss_pkg::rsp_type result
);

   bss_pkg::pitch_type pitch_ff [bss_pkg::COLUMNS];
   bss_pkg::pitch_type pitch_in [bss_pkg::COLUMNS];
   bss_pkg::col_type   col_ff, col_in, col_next, rd_col;
   logic [15:0]        countdown_ff, countdown_in;
   logic               auto_ff, auto_in;
   logic               wait_ff, wait_in;
   logic               left_lock_ff, left_lock_in;
   logic               right_lock_ff, right_lock_in;
   logic               pending_ff;
   logic               left_press, pressed, stepped;
   bss_pkg::pitch_type rd_pitch, pitch_inc;

   assign col_next   = (col_ff == bss_pkg::ColLast) ? '0 : col_ff + 1'b1;
   // wait flag after a mode entry decides whether buttons count
   assign left_press = !(wait_ff || item.enter_mode) && !left_lock_ff
                       && item.left_button == bss_pkg::BtnHeld;
   // left edit reads the cursor column, an auto step reads the one after it
   assign rd_col     = left_press ? col_ff : col_next;
   assign rd_pitch   = pitch_ff[rd_col];
   assign pitch_inc  = rd_pitch + 3'd1;

   always_comb begin
      countdown_in  = countdown_ff;
      auto_in       = auto_ff;
      wait_in       = wait_ff;
      left_lock_in  = left_lock_ff;
      right_lock_in = right_lock_ff;
      col_in        = col_ff;
      pitch_in      = pitch_ff;
      pressed       = 1'b0;
      stepped       = 1'b0;
      result        = '0;

      if (item.tick && countdown_ff != 16'd0) begin
         countdown_in = countdown_ff - 16'd1;
      end
      if (item.enter_mode) begin
         auto_in      = 1'b1;
         countdown_in = cfg.step_ticks;
         wait_in      = 1'b1;
      end

      if (wait_in) begin
         if (item.left_button == bss_pkg::BtnInactive
             && item.right_button == bss_pkg::BtnInactive) begin
            wait_in      = 1'b0;
            countdown_in = auto_in ? cfg.step_ticks : cfg.idle_ticks;
         end
      end else begin
         if (!left_lock_ff) begin
            if (left_press) begin
               pitch_in[col_ff]    = pitch_inc;
               result.store_write  = 1'b1;
               result.store_column = 3'(col_ff);
               result.store_value  = pitch_inc;
               if (pitch_inc == 3'd0) begin
                  result.note_cmd = bss_pkg::NOTE_STOP;
               end else begin
                  result.note_cmd   = bss_pkg::NOTE_PLAY;
                  result.note_index = pitch_inc;
               end
               left_lock_in = 1'b1;
               pressed      = 1'b1;
            end
         end else if (item.left_button == bss_pkg::BtnInactive) begin
            left_lock_in = 1'b0;
         end

         if (!right_lock_ff) begin
            if (item.right_button == bss_pkg::BtnHeld) begin
               col_in        = col_next;
               right_lock_in = 1'b1;
               pressed       = 1'b1;
            end
         end else if (item.right_button == bss_pkg::BtnInactive) begin
            right_lock_in = 1'b0;
         end

         if (pressed) begin
            auto_in      = 1'b0;
            countdown_in = cfg.idle_ticks;
         end else if (countdown_in == 16'd0) begin
            if (auto_in) begin
               col_in = col_next;
               if (rd_pitch != 3'd0) begin
                  result.note_cmd   = bss_pkg::NOTE_PLAY;
                  result.note_index = rd_pitch;
               end
            end else begin
               auto_in = 1'b1;
            end
            countdown_in = cfg.step_ticks;
            stepped      = 1'b1;
         end
      end

      result.redraw        = pending_ff || item.enter_mode || pressed || stepped;
      result.cursor_column = 3'(col_in);
      result.playing       = auto_in;
      for (int c = 0; c < bss_pkg::PackColumns; c++) begin
         result.pattern_word[3*c +: 3] = pitch_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < bss_pkg::COLUMNS; c++) begin
            pitch_ff[c] <= bss_pkg::default_pitch(c);
         end
         col_ff        <= '0;
         countdown_ff  <= bss_pkg::StepTicksReset;
         auto_ff       <= 1'b1;
         wait_ff       <= 1'b1;
         left_lock_ff  <= 1'b0;
         right_lock_ff <= 1'b0;
         pending_ff    <= 1'b1;
      end else if (fire) begin
         pitch_ff      <= pitch_in;
         col_ff        <= col_in;
         countdown_ff  <= countdown_in;
         auto_ff       <= auto_in;
         wait_ff       <= wait_in;
         left_lock_ff  <= left_lock_in;
         right_lock_ff <= right_lock_in;
         pending_ff    <= 1'b0;
      end
   end

endmodule

[rtl/bss_out_reg.sv]
module bss_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bss_pkg::rsp_type result,
   output logic             load_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bss_pkg::rsp_type rsp_payload
);

   logic             valid_ff, valid_in;
   bss_pkg::rsp_type payload_ff;

   assign load_ready  = !valid_ff || rsp_ready;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load_ready) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         payload_ff <= result;
      end
   end

endmodule

[rtl/button_step_sequencer.sv]
// channel  direction  handshake                payload
// req      in         req_valid / req_ready    req_payload (poll: mode, tick, buttons)
// rsp      out        rsp_valid / rsp_ready    rsp_payload (note, store, display)
// csr      in         csr_valid / csr_ready    csr_index, csr_wdata
//
// one transaction per cycle sustained while rsp_ready is high; a req passes through the input
// register and then the result register around the state update
// synchronous active-high reset restores the default pattern, auto-play and
// both times; csr writes are always taken
// a stalled rsp holds its result while the input register still takes one more poll
module button_step_sequencer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bss_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bss_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   bss_pkg::cfg_type cfg_ff, cfg_in;
   bss_pkg::req_type item;
   bss_pkg::rsp_type result;
   logic             item_valid, load_ready, advance;

   assign csr_ready = 1'b1;
   assign advance   = item_valid && load_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bss_pkg::CsrStepTicks: cfg_in.step_ticks = csr_wdata;
            bss_pkg::CsrIdleTicks: cfg_in.idle_ticks = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_ticks <= bss_pkg::StepTicksReset;
         cfg_ff.idle_ticks <= bss_pkg::IdleTicksReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bss_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   bss_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .cfg    (cfg_ff),
      .result (result)
   );

   bss_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .result      (result),
      .load_ready  (load_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/bss_checker.sv]
`include "button_step_sequencer_defines.svh"

module bss_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bss_pkg::rsp_type rsp_payload
);

   logic rsp_stall, play_cmd, index_set, store_ok, store_clear;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign play_cmd    = rsp_payload.note_cmd == bss_pkg::NOTE_PLAY;
   assign index_set   = rsp_payload.note_index != 3'd0;
   assign store_ok    = (rsp_payload.store_value == 3'd0)
                        ? (rsp_payload.note_cmd == bss_pkg::NOTE_STOP)
                        : (rsp_payload.note_index == rsp_payload.store_value);
   assign store_clear = rsp_payload.store_column == 3'd0 && rsp_payload.store_value == 3'd0
                        && rsp_payload.note_cmd != bss_pkg::NOTE_STOP;

   // a stalled result stays put
   `BSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // a played note always carries a pitch, otherwise the index is clear
   `BSS_ASSERT_IMPLY(a_note_index, clock, reset, rsp_valid, play_cmd == index_set)

   // an edit sounds its new pitch, or stops when it wraps to off
   `BSS_ASSERT_IMPLY(a_store_note, clock, reset, rsp_valid && rsp_payload.store_write, store_ok)

   // no store transaction, no store fields and no stop command
   `BSS_ASSERT_IMPLY(a_store_idle, clock, reset, rsp_valid && !rsp_payload.store_write, store_clear)

endmodule

bind button_step_sequencer bss_checker u_bss_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
